/* rtl/neighbor_interval_table_macros.svh */
// assertion macros for the neighbor interval table
// no dependencies; taken in by the files that carry assertions
`ifndef NEIGHBOR_INTERVAL_TABLE_MACROS_SVH
`define NEIGHBOR_INTERVAL_TABLE_MACROS_SVH

// same-cycle implication
`define NIT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("neighbor interval table check failed");

// next-cycle implication
`define NIT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("neighbor interval table check failed");

`endif

/* rtl/nit_pkg.sv */
// shared types and constants of the neighbor interval table
// no dependencies; imported by every module of the block
package nit_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int ID_W = 8;
   localparam int TIME_W = 32;
   localparam int WEIGHT_W = 7;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 9;
   localparam int CSR_IDX_W = 3;

   localparam int PERCENT = 100;
   localparam int SUM_W = TIME_W + WEIGHT_W;

   // divide by one hundred: quarter the sum, then multiply by ceil(2^42 / 25)
   localparam int PART_W = 19;
   localparam int PART_CNT_W = 2;
   localparam int QUO_W = SUM_W - 2;
   localparam int RECIP_W = 2 * PART_W;
   localparam int PROD_W = QUO_W + RECIP_W;
   localparam int RECIP_SHIFT = 42;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 38'd175921860445;

   localparam logic [STATUS_W-1:0] ST_UPDATED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FLUSHED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_WEIGHT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INTERVAL = 3'd3;

   localparam logic [WEIGHT_W-1:0] RST_BLEND_WEIGHT = 7'd20;
   localparam logic [TIME_W-1:0] RST_INTERVAL_LIMIT = 32'd120;
   localparam logic [TIME_W-1:0] RST_AGE_LIMIT = 32'd400;
   localparam logic [TIME_W-1:0] RST_START_INTERVAL = 32'd100;

   typedef struct packed {
      logic valid;
      logic [ID_W-1:0] id;
      logic [TIME_W-1:0] last_time;
      logic [TIME_W-1:0] average;
   } entry_type;

   typedef struct packed {
      logic start;
      logic [WEIGHT_W-1:0] weight;
      logic [TIME_W-1:0] average;
      logic [TIME_W-1:0] delta;
   } blend_req_type;

   typedef struct packed {
      logic done;
      logic [TIME_W-1:0] result;
   } blend_rsp_type;

endpackage

/* rtl/nit_cell.sv */
// one table entry of the rotating entry chain
// depends on nit_pkg
module nit_cell
   import nit_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      shift,
   input  entry_type from_next,
   output entry_type to_prev
);

   logic valid_ff, valid_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [TIME_W-1:0] avg_ff, avg_in;

   always_comb begin
      valid_in = valid_ff;
      id_in = id_ff;
      last_in = last_ff;
      avg_in = avg_ff;
      if (shift) begin
         valid_in = from_next.valid;
         id_in = from_next.id;
         last_in = from_next.last_time;
         avg_in = from_next.average;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      last_ff <= last_in;
      avg_ff <= avg_in;
   end

   assign to_prev = '{valid: valid_ff, id: id_ff, last_time: last_ff, average: avg_ff};

endmodule

/* rtl/nit_blend.sv */
// interval blend unit: two weighted products, then a divide by one hundred done as a
// reciprocal multiply over four partial products; depends on nit_pkg
module nit_blend
   import nit_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  blend_req_type req,
   output blend_rsp_type rsp
);

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_MUL_A = 4'b0010,
      B_MUL_B = 4'b0100,
      B_RECIP = 4'b1000
   } bstate_type;

   bstate_type state_ff, state_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [TIME_W-1:0] avg_ff, avg_in;
   logic [TIME_W-1:0] delta_ff, delta_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PART_CNT_W-1:0] part_ff, part_in;
   logic done_ff, done_in;

   logic [WEIGHT_W-1:0] compl_w;
   logic [QUO_W-1:0] quarter;
   logic [PART_W-1:0] part_x;
   logic [PART_W-1:0] part_m;
   logic [RECIP_W-1:0] part_p;
   logic [PROD_W-1:0] part_sh;

   always_comb begin
      compl_w = WEIGHT_W'(PERCENT) - w_ff;
      quarter = acc_ff[SUM_W-1:2];
      part_x = part_ff[1] ? PART_W'(quarter[QUO_W-1:PART_W]) : quarter[PART_W-1:0];
      part_m = part_ff[0] ? RECIP_MULT[RECIP_W-1:PART_W] : RECIP_MULT[PART_W-1:0];
      part_p = RECIP_W'(part_x) * RECIP_W'(part_m);
      part_sh = PROD_W'(part_p);
      if (part_ff[0]) begin
         part_sh = part_sh << PART_W;
      end
      if (part_ff[1]) begin
         part_sh = part_sh << PART_W;
      end
   end

   always_comb begin
      state_in = state_ff;
      w_in = w_ff;
      avg_in = avg_ff;
      delta_in = delta_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      part_in = part_ff;
      done_in = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (req.start) begin
               w_in = (req.weight > WEIGHT_W'(PERCENT)) ? WEIGHT_W'(PERCENT) : req.weight;
               avg_in = req.average;
               delta_in = req.delta;
               state_in = B_MUL_A;
            end
         end
         B_MUL_A: begin
            acc_in = SUM_W'(compl_w) * SUM_W'(avg_ff);
            state_in = B_MUL_B;
         end
         B_MUL_B: begin
            acc_in = acc_ff + SUM_W'(w_ff) * SUM_W'(delta_ff);
            prod_in = '0;
            part_in = '0;
            state_in = B_RECIP;
         end
         B_RECIP: begin
            prod_in = prod_ff + part_sh;
            part_in = part_ff + PART_CNT_W'(1);
            if (part_ff == '1) begin
               done_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      avg_ff <= avg_in;
      delta_ff <= delta_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      part_ff <= part_in;
   end

   assign rsp = '{done: done_ff, result: prod_ff[RECIP_SHIFT +: TIME_W]};

endmodule

/* rtl/neighbor_interval_table.sv */
// Neighbor interval table, top level; uses nit_pkg, nit_cell, nit_blend and the macro header.
// The entries sit in a ring of TABLE_ENTRIES cells that rotates one place per cycle, while a
// sweep runs, past a single head checker, so every command is one or two sweeps of the ring.
// busy stays high for one sweep after an accepted flush or a table-full answer, two sweeps
// after an update that adds a new neighbor, and two sweeps plus the blend unit's work after an
// update of a known neighbor, the blend being two weighted products and a four-step reciprocal
// multiply for the divide by one hundred. rsp_strobe rises in the first cycle with busy low
// and a new start is taken at the end of that cycle. rsp_strobe lasts one cycle and cannot be
// held off, so the receiver must take it then. Configuration writes are taken at any time
// but belong between commands; csr_ready is always high and unknown indexes are dropped.
`include "neighbor_interval_table_macros.svh"

module neighbor_interval_table
   import nit_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_mode,
   input  logic [ID_W-1:0]      req_neighbor_id,
   input  logic [TIME_W-1:0]    req_time_value,
   output logic                 rsp_strobe,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [COUNT_W-1:0]   rsp_removed_count,
   output logic [TIME_W-1:0]    rsp_mean_interval,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_wdata
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_SCAN  = 5'b00010,
      S_BLEND = 5'b00100,
      S_APPLY = 5'b01000,
      S_FLUSH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic hit_ff, hit_in;
   logic free_ff, free_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] target_ff, target_in;
   logic [TIME_W-1:0] cap_avg_ff, cap_avg_in;
   logic [TIME_W-1:0] cap_last_ff, cap_last_in;
   logic [TIME_W-1:0] new_avg_ff, new_avg_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic blend_start_ff, blend_start_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [TIME_W-1:0] rsp_avg_ff, rsp_avg_in;

   logic [WEIGHT_W-1:0] blend_weight_ff, blend_weight_in;
   logic [TIME_W-1:0] interval_limit_ff, interval_limit_in;
   logic [TIME_W-1:0] age_limit_ff, age_limit_in;
   logic [TIME_W-1:0] start_interval_ff, start_interval_in;

   entry_type cell_q [TABLE_ENTRIES];
   entry_type head;
   entry_type head_mod;
   logic shift;
   logic last_step;
   logic hit_now;
   logic free_now;
   logic stale_now;
   logic [TIME_W-1:0] expire_time;

   blend_req_type blend_req;
   blend_rsp_type blend_rsp;

   // entry ring
   for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
      if (k == TABLE_ENTRIES - 1) begin : g_tail
         nit_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .from_next (head_mod),
            .to_prev   (cell_q[k])
         );
      end else begin : g_body
         nit_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .from_next (cell_q[k+1]),
            .to_prev   (cell_q[k])
         );
      end
   end

   assign blend_req = '{start: blend_start_ff, weight: blend_weight_ff,
                        average: cap_avg_ff, delta: time_ff - cap_last_ff};

   nit_blend u_blend (
      .clock (clock),
      .reset (reset),
      .req   (blend_req),
      .rsp   (blend_rsp)
   );

   // head checks
   always_comb begin
      head = cell_q[0];
      last_step = (step_ff == IDX_W'(TABLE_ENTRIES - 1));
      hit_now = head.valid && (head.id == id_ff) && !hit_ff;
      free_now = !head.valid && !free_ff;
      expire_time = head.last_time + age_limit_ff;
      stale_now = head.valid && ((head.average > interval_limit_ff) || (expire_time < time_ff));
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      id_in = id_ff;
      time_in = time_ff;
      hit_in = hit_ff;
      free_in = free_ff;
      hit_idx_in = hit_idx_ff;
      free_idx_in = free_idx_ff;
      target_in = target_ff;
      cap_avg_in = cap_avg_ff;
      cap_last_in = cap_last_ff;
      new_avg_in = new_avg_ff;
      count_in = count_ff;
      blend_start_in = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in = rsp_count_ff;
      rsp_avg_in = rsp_avg_ff;
      shift = 1'b0;
      head_mod = head;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in = req_neighbor_id;
               time_in = req_time_value;
               step_in = '0;
               hit_in = 1'b0;
               free_in = 1'b0;
               count_in = '0;
               state_in = req_mode ? S_FLUSH : S_SCAN;
            end
         end
         S_SCAN: begin
            shift = 1'b1;
            step_in = step_ff + IDX_W'(1);
            if (hit_now) begin
               hit_in = 1'b1;
               hit_idx_in = step_ff;
               cap_avg_in = head.average;
               cap_last_in = head.last_time;
            end
            if (free_now) begin
               free_in = 1'b1;
               free_idx_in = step_ff;
            end
            if (last_step) begin
               step_in = '0;
               if (hit_ff || hit_now) begin
                  target_in = hit_now ? step_ff : hit_idx_ff;
                  blend_start_in = 1'b1;
                  state_in = S_BLEND;
               end else if (free_ff || free_now) begin
                  target_in = free_now ? step_ff : free_idx_ff;
                  new_avg_in = start_interval_ff;
                  state_in = S_APPLY;
               end else begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = ST_FULL;
                  rsp_count_in = '0;
                  rsp_avg_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         S_BLEND: begin
            if (blend_rsp.done) begin
               new_avg_in = blend_rsp.result;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            shift = 1'b1;
            step_in = step_ff + IDX_W'(1);
            if (step_ff == target_ff) begin
               head_mod = '{valid: 1'b1, id: id_ff, last_time: time_ff, average: new_avg_ff};
            end
            if (last_step) begin
               step_in = '0;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_UPDATED;
               rsp_count_in = '0;
               rsp_avg_in = new_avg_ff;
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            shift = 1'b1;
            step_in = step_ff + IDX_W'(1);
            if (stale_now) begin
               head_mod.valid = 1'b0;
               count_in = count_ff + CNT_W'(1);
            end
            if (last_step) begin
               step_in = '0;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ST_FLUSHED;
               rsp_count_in = COUNT_W'(count_in);
               rsp_avg_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control and status registers
   always_comb begin
      blend_weight_in = blend_weight_ff;
      interval_limit_in = interval_limit_ff;
      age_limit_in = age_limit_ff;
      start_interval_in = start_interval_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLEND_WEIGHT:   blend_weight_in = csr_wdata[WEIGHT_W-1:0];
            CSR_INTERVAL_LIMIT: interval_limit_in = csr_wdata;
            CSR_AGE_LIMIT:      age_limit_in = csr_wdata;
            CSR_START_INTERVAL: start_interval_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         blend_start_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         blend_weight_ff <= RST_BLEND_WEIGHT;
         interval_limit_ff <= RST_INTERVAL_LIMIT;
         age_limit_ff <= RST_AGE_LIMIT;
         start_interval_ff <= RST_START_INTERVAL;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         blend_start_ff <= blend_start_in;
         rsp_strobe_ff <= rsp_strobe_in;
         blend_weight_ff <= blend_weight_in;
         interval_limit_ff <= interval_limit_in;
         age_limit_ff <= age_limit_in;
         start_interval_ff <= start_interval_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      time_ff <= time_in;
      hit_ff <= hit_in;
      free_ff <= free_in;
      hit_idx_ff <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      target_ff <= target_in;
      cap_avg_ff <= cap_avg_in;
      cap_last_ff <= cap_last_in;
      new_avg_ff <= new_avg_in;
      count_ff <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff <= rsp_count_in;
      rsp_avg_ff <= rsp_avg_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_removed_count = rsp_count_ff;
   assign rsp_mean_interval = rsp_avg_ff;

   `NIT_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `NIT_ASSERT_NOW(a_rsp_idle, clock, reset, rsp_strobe, !busy)
   `NIT_ASSERT_NOW(a_rsp_count, clock, reset, rsp_strobe,
                   (rsp_status == ST_FLUSHED) || (rsp_removed_count == '0))
   `NIT_ASSERT_NOW(a_flush_bound, clock, reset, rsp_strobe && (rsp_status == ST_FLUSHED),
                   rsp_removed_count <= COUNT_W'(TABLE_ENTRIES))

endmodule

/* bench/neighbor_interval_table_test.sv */
`timescale 1ns / 1ps
// self-checking bench for neighbor_interval_table: update and flush commands plus register
// writes, each response checked against a behavioral model of the neighbor table
// depends on nit_pkg and the neighbor_interval_table rtl
module neighbor_interval_table_test;
   import nit_pkg::*;

   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;
   localparam int PHASES = 9;
   localparam int PHASE_ITEMS = 50;
   localparam int STEADY_PHASE = 4;
   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 120;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  removed;
      logic [TIME_W-1:0]   average;
   } answer_type;

   class neighbor_table_tracker_type;
      bit [WEIGHT_W-1:0] weight;
      bit [TIME_W-1:0]   interval_limit;
      bit [TIME_W-1:0]   age_limit;
      bit [TIME_W-1:0]   start_interval;
      bit                valid [TABLE_ENTRIES];
      bit [ID_W-1:0]     id [TABLE_ENTRIES];
      bit [TIME_W-1:0]   last_time [TABLE_ENTRIES];
      bit [TIME_W-1:0]   average [TABLE_ENTRIES];
      answer_type        pending_answers [$];
      int                failures;

      function new();
         weight = RST_BLEND_WEIGHT;
         interval_limit = RST_INTERVAL_LIMIT;
         age_limit = RST_AGE_LIMIT;
         start_interval = RST_START_INTERVAL;
         foreach (valid[i]) valid[i] = 1'b0;
         failures = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] index, logic [TIME_W-1:0] data);
         case (index)
            CSR_BLEND_WEIGHT:   weight = data[WEIGHT_W-1:0];
            CSR_INTERVAL_LIMIT: interval_limit = data;
            CSR_AGE_LIMIT:      age_limit = data;
            CSR_START_INTERVAL: start_interval = data;
            default: ;
         endcase
      endfunction

      // weights above one hundred saturate; the sum is kept exact before the divide
      function bit [TIME_W-1:0] blended(bit [TIME_W-1:0] avg, bit [TIME_W-1:0] delta);
         bit [63:0] w;
         bit [63:0] sum;
         w = (weight > PERCENT) ? 64'(PERCENT) : 64'(weight);
         sum = (64'(PERCENT) - w) * 64'(avg) + w * 64'(delta);
         return TIME_W'(sum / 64'(PERCENT));
      endfunction

      function void note_command(logic mode, logic [ID_W-1:0] nid, logic [TIME_W-1:0] t);
         answer_type ans;
         int hit;
         int free_slot;
         int removed;
         bit [TIME_W-1:0] deadline;
         ans = '0;
         hit = -1;
         free_slot = -1;
         removed = 0;
         if (mode == MODE_FLUSH) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               deadline = last_time[i] + age_limit;
               if (valid[i] && (average[i] > interval_limit || deadline < t)) begin
                  valid[i] = 1'b0;
                  removed++;
               end
            end
            ans.status = ST_FLUSHED;
            ans.removed = COUNT_W'(removed);
         end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (valid[i]) begin
                  if (hit < 0 && id[i] == nid) hit = i;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (hit >= 0) begin
               average[hit] = blended(average[hit], t - last_time[hit]);
               last_time[hit] = t;
               ans.status = ST_UPDATED;
               ans.average = average[hit];
            end else if (free_slot >= 0) begin
               valid[free_slot] = 1'b1;
               id[free_slot] = nid;
               average[free_slot] = start_interval;
               last_time[free_slot] = t;
               ans.status = ST_UPDATED;
               ans.average = start_interval;
            end else begin
               ans.status = ST_FULL;
            end
         end
         pending_answers.push_back(ans);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] removed,
                                   logic [TIME_W-1:0] avg);
         answer_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: response with no transaction outstanding: status %0d count %0d avg %0d",
                     $time, status, removed, avg);
            failures++;
            return;
         end
         want = pending_answers.pop_front();
         if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            failures++;
         end
         if (removed !== want.removed) begin
            $display("%0t: removed_count expected %0d actual %0d", $time, want.removed, removed);
            failures++;
         end
         if (avg !== want.average) begin
            $display("%0t: mean interval expected %0d actual %0d", $time, want.average, avg);
            failures++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_mode = MODE_UPDATE;
   logic [ID_W-1:0]      req_neighbor_id = '0;
   logic [TIME_W-1:0]    req_time_value = '0;
   logic                 rsp_strobe;
   logic [STATUS_W-1:0]  rsp_status;
   logic [COUNT_W-1:0]   rsp_removed_count;
   logic [TIME_W-1:0]    rsp_mean_interval;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0]    csr_wdata = '0;

   neighbor_table_tracker_type tracker;
   logic [TIME_W-1:0]          tick_now = '0;
   bit                         steady = 1'b0;
   int                         cycles = 0;

   neighbor_interval_table DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_mode(req_mode),
      .req_neighbor_id(req_neighbor_id),
      .req_time_value(req_time_value),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_removed_count(rsp_removed_count),
      .rsp_mean_interval(rsp_mean_interval),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("neighbor_interval_table verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_response(rsp_status, rsp_removed_count, rsp_mean_interval);
   end

   // start stays high after acceptance so back-to-back transactions need no second assignment
   task automatic issue(input logic mode, input logic [ID_W-1:0] nid,
                        input logic [TIME_W-1:0] t);
      start <= 1'b1;
      req_mode <= mode;
      req_neighbor_id <= nid;
      req_time_value <= t;
      do @(posedge clock); while (busy);
      tracker.note_command(mode, nid, t);
   endtask

   task automatic maybe_idle();
      int gap;
      if (!steady && $urandom_range(99) < 23) begin
         gap = ($urandom_range(9) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 6);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (tracker.pending_answers.size() != 0 || busy);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index, input logic [TIME_W-1:0] data);
      if (!steady && $urandom_range(99) < 23) repeat ($urandom_range(1, 4)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_unused_regs();
      for (int k = int'(CSR_START_INTERVAL) + 1; k < (1 << CSR_IDX_W); k++)
         csr_write(CSR_IDX_W'(k), $urandom());
   endtask

   task automatic set_phase(input int p);
      logic [TIME_W-1:0] w;
      logic [TIME_W-1:0] il;
      logic [TIME_W-1:0] al;
      logic [TIME_W-1:0] si;
      case (p)
         0: begin
            w = 0; il = 0; al = 0; si = 0;
         end
         1: begin
            w = 127; il = TIME_MAX; al = TIME_MAX; si = TIME_MAX;
         end
         2: begin
            w = 50; il = TIME_MAX; al = $urandom_range(200, 2000); si = TIME_MAX;
         end
         3: begin
            w = 100; il = $urandom(); al = $urandom(); si = $urandom();
         end
         default: begin
            w = $urandom_range(0, 127);
            il = $urandom_range(60, 2000);
            al = $urandom_range(100, 3000);
            si = $urandom_range(0, 400);
         end
      endcase
      // high bits of the weight write are dropped by the block
      if ($urandom_range(1)) w[TIME_W-1:WEIGHT_W] = (TIME_W-WEIGHT_W)'($urandom());
      csr_write(CSR_BLEND_WEIGHT, w);
      csr_write(CSR_INTERVAL_LIMIT, il);
      csr_write(CSR_AGE_LIMIT, al);
      csr_write(CSR_START_INTERVAL, si);
      if (p % 3 == 0) write_unused_regs();
   endtask

   task automatic random_item(input bit wide_ids);
      logic              mode;
      logic [ID_W-1:0]   nid;
      logic [TIME_W-1:0] t;
      mode = ($urandom_range(7) == 0) ? MODE_FLUSH : MODE_UPDATE;
      nid = (wide_ids || $urandom_range(9) == 0) ? ID_W'($urandom_range(255))
                                                 : ID_W'($urandom_range(23));
      case ($urandom_range(9))
         0: t = $urandom();
         1: t = tick_now - $urandom_range(0, 1000);
         default: begin
            tick_now = tick_now + $urandom_range(0, 300);
            t = (mode == MODE_FLUSH) ? tick_now + $urandom_range(0, 600) : tick_now;
         end
      endcase
      issue(mode, nid, t);
   endtask

   initial begin
      tracker = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      write_unused_regs();

      // empty table, new neighbors at the time extremes, wrapping interval, fill, full, flush
      issue(MODE_FLUSH, 8'd0, '0);
      issue(MODE_UPDATE, 8'd0, '0);
      issue(MODE_UPDATE, 8'd255, TIME_MAX);
      issue(MODE_UPDATE, 8'd0, 32'd50);
      issue(MODE_UPDATE, 8'd255, 32'd10);
      for (int k = 1; k <= TABLE_ENTRIES - 2; k++) begin
         maybe_idle();
         issue(MODE_UPDATE, ID_W'(k), TIME_W'(100 * k));
      end
      issue(MODE_UPDATE, 8'd200, 32'd2000);
      issue(MODE_UPDATE, 8'd0, 32'd1000);
      issue(MODE_FLUSH, 8'd255, TIME_MAX);
      issue(MODE_UPDATE, 8'd170, 32'h5555_5555);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         steady = (p == STEADY_PHASE);
         set_phase(p);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            maybe_idle();
            random_item(p == 3 || p == 6);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending_answers.size() == 0) begin
         $display("neighbor_interval_table verification clean");
      end else begin
         $display("neighbor_interval_table verification failed");
      end
      $finish;
   end

endmodule
